// ===== hdl/hrst_pkg.sv =====
package hrst_pkg;

   localparam int NAME_W   = 48;
   localparam int COUNT_W  = 12;
   localparam int BYTE_W   = 8;
   localparam int SLOT_NUM = 4;
   localparam int INDEX_W  = 8;

   localparam int DEF_MAX_METHOD_LEN  = 6;
   localparam int DEF_MAX_URL_LEN     = 2048;
   localparam int DEF_MAX_VERSION_LEN = 8;

   localparam logic [NAME_W-1:0] RESET_NAME_A = 48'd4670804;
   localparam logic [NAME_W-1:0] RESET_NAME_B = 48'd1347375956;
   localparam logic [NAME_W-1:0] RESET_NAME_C = 48'd5264724;
   localparam logic [NAME_W-1:0] RESET_NAME_D = 48'd75064423044165;

   localparam logic [INDEX_W-1:0] REG_METHOD_A = 8'd0;
   localparam logic [INDEX_W-1:0] REG_METHOD_B = 8'd1;
   localparam logic [INDEX_W-1:0] REG_METHOD_C = 8'd2;
   localparam logic [INDEX_W-1:0] REG_METHOD_D = 8'd3;

   localparam logic [2:0] PH_METHOD  = 3'd0;
   localparam logic [2:0] PH_URL     = 3'd1;
   localparam logic [2:0] PH_VERSION = 3'd2;
   localparam logic [2:0] PH_KEY     = 3'd3;
   localparam logic [2:0] PH_VALUE   = 3'd4;
   localparam logic [2:0] PH_BODY    = 3'd5;
   localparam logic [2:0] PH_ERROR   = 3'd6;

   localparam logic [2:0] TAG_DELIM   = 3'd0;
   localparam logic [2:0] TAG_METHOD  = 3'd1;
   localparam logic [2:0] TAG_PATH    = 3'd2;
   localparam logic [2:0] TAG_QUERY   = 3'd3;
   localparam logic [2:0] TAG_VERSION = 3'd4;
   localparam logic [2:0] TAG_KEY     = 3'd5;
   localparam logic [2:0] TAG_VALUE   = 3'd6;
   localparam logic [2:0] TAG_BODY    = 3'd7;

   localparam logic [1:0] ST_PROGRESS = 2'd0;
   localparam logic [1:0] ST_OK       = 2'd1;
   localparam logic [1:0] ST_BAD      = 2'd2;
   localparam logic [1:0] ST_LONG     = 2'd3;

   localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2f;
   localparam logic [BYTE_W-1:0] CH_QUERY = 8'h3f;
   localparam logic [BYTE_W-1:0] CH_COLON = 8'h3a;
   localparam logic [BYTE_W-1:0] CH_CR    = 8'h0d;
   localparam logic [BYTE_W-1:0] CH_LF    = 8'h0a;

   typedef struct packed {
      logic [2:0]         phase;
      logic [COUNT_W-1:0] count;
      logic [NAME_W-1:0]  mbuf;
      logic [1:0]         slot;
      logic               query;
      logic               key_seen;
      logic               value_seen;
      logic               pending_cr;
      logic               line_start;
      logic [1:0]         err;
   } state_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic [2:0]        tag;
      logic [1:0]        slot;
      logic [1:0]        status;
      logic              done;
   } result_type;

endpackage

// ===== hdl/hrst_step.sv =====
module hrst_step #(
   parameter int MaxMethodLen  = hrst_pkg::DEF_MAX_METHOD_LEN,
   parameter int MaxUrlLen     = hrst_pkg::DEF_MAX_URL_LEN,
   parameter int MaxVersionLen = hrst_pkg::DEF_MAX_VERSION_LEN
) (
   input  hrst_pkg::state_type                                       cur,
   input  logic [hrst_pkg::SLOT_NUM-1:0][hrst_pkg::NAME_W-1:0]       names,
   input  logic [hrst_pkg::BYTE_W-1:0]                               in_byte,
   input  logic                                                      last_byte,
   output hrst_pkg::state_type                                       nxt,
   output hrst_pkg::result_type                                      res
);

   logic       printable;
   logic       hit;
   logic [1:0] hit_slot;
   logic [2:0] tag;
   logic [1:0] status;

   assign printable = !in_byte[7] && (in_byte >= hrst_pkg::CH_SPACE);

   // lowest matching slot wins
   always_comb begin
      hit      = 1'b0;
      hit_slot = 2'd0;
      for (int k = hrst_pkg::SLOT_NUM - 1; k >= 0; k--) begin
         if (names[k] != '0 && names[k] == cur.mbuf) begin
            hit      = 1'b1;
            hit_slot = 2'(k);
         end
      end
   end

   always_comb begin
      nxt    = cur;
      tag    = hrst_pkg::TAG_DELIM;
      status = hrst_pkg::ST_PROGRESS;
      unique case (cur.phase)
         hrst_pkg::PH_METHOD: begin
            priority if (!printable) begin
               nxt.err   = hrst_pkg::ST_BAD;
               nxt.phase = hrst_pkg::PH_ERROR;
            end else if (in_byte == hrst_pkg::CH_SPACE) begin
               if (cur.count == '0 || !hit) begin
                  nxt.err   = hrst_pkg::ST_BAD;
                  nxt.phase = hrst_pkg::PH_ERROR;
               end else begin
                  nxt.slot  = hit_slot;
                  nxt.phase = hrst_pkg::PH_URL;
                  nxt.count = '0;
               end
            end else if (cur.count >= hrst_pkg::COUNT_W'(MaxMethodLen)) begin
               nxt.err   = hrst_pkg::ST_BAD;
               nxt.phase = hrst_pkg::PH_ERROR;
            end else begin
               nxt.mbuf  = {cur.mbuf[hrst_pkg::NAME_W-hrst_pkg::BYTE_W-1:0], in_byte};
               nxt.count = cur.count + hrst_pkg::COUNT_W'(1);
               tag       = hrst_pkg::TAG_METHOD;
            end
         end
         hrst_pkg::PH_URL: begin
            priority if (!printable ||
                         (cur.count == '0 && in_byte != hrst_pkg::CH_SLASH)) begin
               nxt.err   = hrst_pkg::ST_BAD;
               nxt.phase = hrst_pkg::PH_ERROR;
            end else if (in_byte == hrst_pkg::CH_SPACE) begin
               nxt.phase = hrst_pkg::PH_VERSION;
               nxt.count = '0;
               nxt.query = 1'b0;
            end else if (cur.count >= hrst_pkg::COUNT_W'(MaxUrlLen)) begin
               nxt.err   = hrst_pkg::ST_LONG;
               nxt.phase = hrst_pkg::PH_ERROR;
            end else begin
               nxt.count = cur.count + hrst_pkg::COUNT_W'(1);
               if (cur.query) begin
                  tag = hrst_pkg::TAG_QUERY;
               end else if (in_byte == hrst_pkg::CH_QUERY) begin
                  nxt.query = 1'b1;
               end else begin
                  tag = hrst_pkg::TAG_PATH;
               end
            end
         end
         hrst_pkg::PH_VERSION: begin
            priority if (cur.pending_cr) begin
               if (in_byte != hrst_pkg::CH_LF) begin
                  nxt.err   = hrst_pkg::ST_BAD;
                  nxt.phase = hrst_pkg::PH_ERROR;
               end else begin
                  nxt.pending_cr = 1'b0;
                  nxt.count      = '0;
                  nxt.phase      = hrst_pkg::PH_KEY;
                  nxt.line_start = 1'b1;
                  nxt.key_seen   = 1'b0;
               end
            end else if (in_byte == hrst_pkg::CH_CR) begin
               nxt.pending_cr = 1'b1;
            end else if (!printable ||
                         cur.count >= hrst_pkg::COUNT_W'(MaxVersionLen)) begin
               nxt.err   = hrst_pkg::ST_BAD;
               nxt.phase = hrst_pkg::PH_ERROR;
            end else begin
               nxt.count = cur.count + hrst_pkg::COUNT_W'(1);
               tag       = hrst_pkg::TAG_VERSION;
            end
         end
         hrst_pkg::PH_KEY: begin
            priority if (cur.pending_cr) begin
               if (in_byte != hrst_pkg::CH_LF) begin
                  nxt.err   = hrst_pkg::ST_BAD;
                  nxt.phase = hrst_pkg::PH_ERROR;
               end else begin
                  nxt.pending_cr = 1'b0;
                  nxt.line_start = 1'b0;
                  nxt.phase      = hrst_pkg::PH_BODY;
               end
            end else if (in_byte == hrst_pkg::CH_CR) begin
               if (!cur.line_start) begin
                  nxt.err   = hrst_pkg::ST_BAD;
                  nxt.phase = hrst_pkg::PH_ERROR;
               end else begin
                  nxt.pending_cr = 1'b1;
               end
            end else if (!printable) begin
               nxt.err   = hrst_pkg::ST_BAD;
               nxt.phase = hrst_pkg::PH_ERROR;
            end else if (in_byte == hrst_pkg::CH_COLON) begin
               if (!cur.key_seen) begin
                  nxt.err   = hrst_pkg::ST_BAD;
                  nxt.phase = hrst_pkg::PH_ERROR;
               end else begin
                  nxt.phase      = hrst_pkg::PH_VALUE;
                  nxt.value_seen = 1'b0;
               end
            end else begin
               nxt.key_seen   = 1'b1;
               nxt.line_start = 1'b0;
               tag            = hrst_pkg::TAG_KEY;
            end
         end
         hrst_pkg::PH_VALUE: begin
            priority if (cur.pending_cr) begin
               if (in_byte != hrst_pkg::CH_LF) begin
                  nxt.err   = hrst_pkg::ST_BAD;
                  nxt.phase = hrst_pkg::PH_ERROR;
               end else begin
                  nxt.pending_cr = 1'b0;
                  nxt.phase      = hrst_pkg::PH_KEY;
                  nxt.line_start = 1'b1;
                  nxt.key_seen   = 1'b0;
                  nxt.value_seen = 1'b0;
               end
            end else if (in_byte == hrst_pkg::CH_CR) begin
               if (!cur.value_seen) begin
                  nxt.err   = hrst_pkg::ST_BAD;
                  nxt.phase = hrst_pkg::PH_ERROR;
               end else begin
                  nxt.pending_cr = 1'b1;
               end
            end else if (!printable) begin
               nxt.err   = hrst_pkg::ST_BAD;
               nxt.phase = hrst_pkg::PH_ERROR;
            end else begin
               nxt.value_seen = 1'b1;
               tag            = hrst_pkg::TAG_VALUE;
            end
         end
         hrst_pkg::PH_BODY: begin
            tag = hrst_pkg::TAG_BODY;
         end
         default: begin
            tag = hrst_pkg::TAG_DELIM;
         end
      endcase

      res.out_byte = in_byte;
      res.tag      = tag;
      res.slot     = nxt.slot;
      res.done     = last_byte;

      // final status, then back to a fresh request
      if (last_byte) begin
         priority if (nxt.err != hrst_pkg::ST_PROGRESS) begin
            status = nxt.err;
         end else if (nxt.phase == hrst_pkg::PH_BODY) begin
            status = hrst_pkg::ST_OK;
         end else begin
            status = hrst_pkg::ST_BAD;
         end
         nxt       = '0;
         nxt.phase = hrst_pkg::PH_METHOD;
      end
      res.status = status;
   end

endmodule

// ===== hdl/http_request_stream_tokenizer_top.sv =====
// http request tokenizer
// request channel: one request byte per transfer (req_in_byte), with
// req_last_byte on the final byte of a request buffer; taken when req_valid is
// high and req_stall low
// response channel: one tagged byte per request byte, with field tag, method
// slot, parse status and request_done; taken when rsp_valid is high and
// rsp_stall low
// csr channel: csr_index 0..3 selects method name a..d, csr_data the 48-bit
// name packed right-aligned; csr_ready is always high, other indexes ignored
// output: the response appears in the cycle after its request is taken, from the response register
// throughput: one byte per cycle while req_stall is low, set by the single parse step between the
// parser state registers and the response register
// stall: while the response register holds an untaken byte and rsp_stall is
// high, req_stall is high; otherwise a new byte is taken every cycle
// reset: parser back to the method phase, response empty, method names GET,
// POST, PUT and DELETE; parser state also clears after every last byte
module http_request_stream_tokenizer_top #(
   parameter int MaxMethodLen  = hrst_pkg::DEF_MAX_METHOD_LEN,
   parameter int MaxUrlLen     = hrst_pkg::DEF_MAX_URL_LEN,
   parameter int MaxVersionLen = hrst_pkg::DEF_MAX_VERSION_LEN
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [hrst_pkg::BYTE_W-1:0]       req_in_byte,
   input  logic                              req_last_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [hrst_pkg::BYTE_W-1:0]       rsp_out_byte,
   output logic [2:0]                        rsp_field_tag,
   output logic [1:0]                        rsp_method_slot,
   output logic [1:0]                        rsp_parse_status,
   output logic                              rsp_request_done,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [hrst_pkg::INDEX_W-1:0]      csr_index,
   input  logic [hrst_pkg::NAME_W-1:0]       csr_data
);

   hrst_pkg::state_type                                  state_ff, state_in, step_state;
   hrst_pkg::result_type                                 rsp_ff, rsp_in, step_res;
   logic                                                 rsp_valid_ff, rsp_valid_in;
   logic [hrst_pkg::SLOT_NUM-1:0][hrst_pkg::NAME_W-1:0]  names_ff, names_in;
   logic                                                 accept;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   hrst_step #(
      .MaxMethodLen  (MaxMethodLen),
      .MaxUrlLen     (MaxUrlLen),
      .MaxVersionLen (MaxVersionLen)
   ) u_step (
      .cur       (state_ff),
      .names     (names_ff),
      .in_byte   (req_in_byte),
      .last_byte (req_last_byte),
      .nxt       (step_state),
      .res       (step_res)
   );

   always_comb begin
      state_in     = state_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         state_in     = step_state;
         rsp_in       = step_res;
         rsp_valid_in = 1'b1;
      end
   end

   always_comb begin
      names_in = names_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            hrst_pkg::REG_METHOD_A: names_in[0] = csr_data;
            hrst_pkg::REG_METHOD_B: names_in[1] = csr_data;
            hrst_pkg::REG_METHOD_C: names_in[2] = csr_data;
            hrst_pkg::REG_METHOD_D: names_in[3] = csr_data;
            default: names_in = names_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '{phase: hrst_pkg::PH_METHOD, default: '0};
         rsp_valid_ff <= 1'b0;
         names_ff     <= {hrst_pkg::RESET_NAME_D, hrst_pkg::RESET_NAME_C,
                          hrst_pkg::RESET_NAME_B, hrst_pkg::RESET_NAME_A};
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         names_ff     <= names_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_byte     = rsp_ff.out_byte;
   assign rsp_field_tag    = rsp_ff.tag;
   assign rsp_method_slot  = rsp_ff.slot;
   assign rsp_parse_status = rsp_ff.status;
   assign rsp_request_done = rsp_ff.done;

   a_status_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status != hrst_pkg::ST_PROGRESS) |-> rsp_ff.done)
      else $error("status reported before the last byte");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (accept && req_last_byte) |=>
      (state_ff.phase == hrst_pkg::PH_METHOD && state_ff.count == '0 &&
       state_ff.err == hrst_pkg::ST_PROGRESS))
      else $error("parser not cleared after last byte");

   a_error_phase: assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase == hrst_pkg::PH_ERROR) == (state_ff.err != hrst_pkg::ST_PROGRESS))
      else $error("error phase and error code disagree");

   a_body_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.done && rsp_ff.tag == hrst_pkg::TAG_BODY) |->
      (rsp_ff.status == hrst_pkg::ST_OK))
      else $error("body byte ended a request without ok status");

endmodule
